// ===== rtl/collision_sensitivity_level_select_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensitivity level select block
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef COLLISION_SENSITIVITY_LEVEL_SELECT_MACROS_SVH
`define COLLISION_SENSITIVITY_LEVEL_SELECT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define CSLS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define CSLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define CSLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csls_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensitivity level select package
// Band tables, table mode codes and the result types shared by the block.
// ----------------------------------------------------------------------------
package csls_pkg;

    // Table mode register codes.
    localparam logic MODE_TCAS = 1'b0;
    localparam logic MODE_GEAR = 1'b1;

    // Gear test codes of a band.
    localparam logic [1:0] GEAR_NONE = 2'd0;
    localparam logic [1:0] GEAR_DN   = 2'd1;
    localparam logic [1:0] GEAR_UP   = 2'd2;

    // Largest table size and the index width that covers it.
    localparam int NUM_BANDS   = 8;
    localparam int BAND_IDX_W  = 3;
    localparam int LEVEL_W     = 4;
    localparam int BOUND_W     = 18;
    localparam int HYST_W      = 9;

    // Advisory thresholds of one level.
    typedef struct packed {
        logic [3:0]  level_id;
        logic [5:0]  tau_ta_s;
        logic [5:0]  tau_ra_s;
        logic [7:0]  dmod_ta_cnm;
        logic [6:0]  dmod_ra_cnm;
        logic [10:0] zthr_ta_ft;
        logic [9:0]  zthr_ra_ft;
        logic [9:0]  alim_ft;
    } thresh_t;

    // One altitude band of a table.
    typedef struct packed {
        logic                       on_agl;
        logic [1:0]                 gear;
        logic                       lo_open;
        logic                       hi_open;
        logic signed [BOUND_W-1:0]  lo;
        logic signed [BOUND_W-1:0]  hi;
        logic [HYST_W-1:0]          hyst_lo;
        logic [HYST_W-1:0]          hyst_hi;
        thresh_t                    thr;
    } band_t;

    // Outcome of the level pick for one beat.
    typedef struct packed {
        thresh_t thr;
        logic    force_error;
    } result_t;

    // Assemble a band from plain numbers.
    function automatic band_t mk_band(
        input logic       on_agl,
        input logic [1:0] gear,
        input logic       lo_open,
        input logic       hi_open,
        input int         lo,
        input int         hi,
        input int         hyst_lo,
        input int         hyst_hi,
        input int         id,
        input int         tta,
        input int         tra,
        input int         dta,
        input int         dra,
        input int         zta,
        input int         zra,
        input int         alim
    );
        band_t b;
        b.on_agl           = on_agl;
        b.gear             = gear;
        b.lo_open          = lo_open;
        b.hi_open          = hi_open;
        b.lo               = BOUND_W'(lo);
        b.hi               = BOUND_W'(hi);
        b.hyst_lo          = HYST_W'(hyst_lo);
        b.hyst_hi          = HYST_W'(hyst_hi);
        b.thr.level_id     = 4'(id);
        b.thr.tau_ta_s     = 6'(tta);
        b.thr.tau_ra_s     = 6'(tra);
        b.thr.dmod_ta_cnm  = 8'(dta);
        b.thr.dmod_ra_cnm  = 7'(dra);
        b.thr.zthr_ta_ft   = 11'(zta);
        b.thr.zthr_ra_ft   = 10'(zra);
        b.thr.alim_ft      = 10'(alim);
        return b;
    endfunction

    // Band table lookup. Entries past the table size are never selected.
    function automatic band_t band_entry(input logic mode, input logic [BAND_IDX_W-1:0] idx);
        band_t b;
        b = '0;
        if (mode == MODE_GEAR) begin
            unique case (idx)
                3'd0:    b = mk_band(1'b1, GEAR_NONE, 1'b1, 1'b0, 0, 50, 0, 10,
                                     1, 0, 0, 0, 0, 0, 0, 0);
                3'd1:    b = mk_band(1'b1, GEAR_DN, 1'b0, 1'b0, 50, 2000, 10, 100,
                                     2, 20, 0, 20, 0, 600, 0, 0);
                3'd2:    b = mk_band(1'b1, GEAR_UP, 1'b0, 1'b1, 2000, 0, 100, 100,
                                     3, 30, 0, 55, 0, 800, 0, 0);
                default: b = '0;
            endcase
        end else begin
            unique case (idx)
                3'd0: b = mk_band(1'b1, GEAR_NONE, 1'b1, 1'b0, 0, 50, 0, 10,
                                  1, 0, 0, 0, 0, 0, 0, 0);
                3'd1: b = mk_band(1'b1, GEAR_NONE, 1'b0, 1'b0, 50, 1000, 10, 100,
                                  2, 20, 0, 30, 0, 850, 0, 0);
                3'd2: b = mk_band(1'b1, GEAR_NONE, 1'b0, 1'b0, 1000, 2350, 100, 200,
                                  3, 25, 15, 33, 20, 850, 600, 300);
                3'd3: b = mk_band(1'b0, GEAR_NONE, 1'b1, 1'b0, 0, 5000, 0, 500,
                                  4, 30, 20, 48, 35, 850, 600, 300);
                3'd4: b = mk_band(1'b0, GEAR_NONE, 1'b0, 1'b0, 5000, 10000, 500, 500,
                                  5, 40, 25, 75, 55, 850, 600, 350);
                3'd5: b = mk_band(1'b0, GEAR_NONE, 1'b0, 1'b0, 10000, 20000, 500, 500,
                                  6, 45, 30, 100, 80, 850, 600, 400);
                3'd6: b = mk_band(1'b0, GEAR_NONE, 1'b0, 1'b0, 20000, 42000, 500, 500,
                                  7, 48, 35, 130, 110, 850, 700, 600);
                3'd7: b = mk_band(1'b0, GEAR_NONE, 1'b0, 1'b1, 42000, 0, 500, 500,
                                  8, 48, 35, 130, 110, 1200, 800, 700);
                default: b = '0;
            endcase
        end
        return b;
    endfunction

    // Number of levels in the selected table.
    function automatic logic [LEVEL_W-1:0] band_count(input logic mode);
        return (mode == MODE_GEAR) ? 4'd3 : 4'd8;
    endfunction

    // Table index chosen when the baro altitude is not usable.
    function automatic logic [BAND_IDX_W-1:0] fallback_idx(input logic mode);
        return (mode == MODE_GEAR) ? 3'd1 : 3'd3;
    endfunction

endpackage

// ===== rtl/collision_sensitivity_level_select.sv =====
// ----------------------------------------------------------------------------
// Collision sensitivity level select
// Picks a collision-avoidance sensitivity level from altitude bands and
// returns the level with its advisory thresholds.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Direction  Carries
//  in        in_valid / in_stall   input      altitudes, flags, gear, forced level
//  out       out_valid / out_stall output     level and advisory thresholds
//  cfg       cfg_we / cfg_wdata    input      table mode register
//
// One beat in per clock cycle while in_stall is low; its result is shown from the result register.
// The input register and the result register form a two-entry pipeline, so a
// new beat is taken while a finished result waits on out_stall.
// The last selected level updates as each beat enters the result register.
// Reset clears the pipeline, the last level and the table mode.
//
module collision_sensitivity_level_select
    import csls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [16:0] alt_msl_ft,
    input  logic               msl_valid,
    input  logic signed [14:0] alt_agl_ft,
    input  logic               agl_valid,
    input  logic               gear_down,
    input  logic [3:0]         force_level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         level_id,
    output logic [5:0]         tau_ta_s,
    output logic [5:0]         tau_ra_s,
    output logic [7:0]         dmod_ta_cnm,
    output logic [6:0]         dmod_ra_cnm,
    output logic [10:0]        zthr_ta_ft,
    output logic [9:0]         zthr_ra_ft,
    output logic [9:0]         alim_ft,
    output logic               force_error
);

`include "collision_sensitivity_level_select_macros.svh"

    logic               table_mode_reg;
    logic [LEVEL_W-1:0] last_level_reg;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic signed [16:0] msl_reg;
    logic               msl_ok_reg;
    logic signed [14:0] agl_reg;
    logic               agl_ok_reg;
    logic               gear_reg;
    logic [3:0]         force_reg;
    result_t            result_reg;
    result_t            pick_result;
    logic               s2_ready;
    logic               s1_move;
    logic               in_accept;

    // Pipeline handshake.
    assign s2_ready       = !out_valid_reg || !out_stall;
    assign s1_move        = s1_valid_reg && s2_ready;
    assign in_stall       = s1_valid_reg && !s2_ready;
    assign in_accept      = in_valid && !in_stall;
    assign s1_valid_next  = in_accept || (s1_valid_reg && !s2_ready);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            table_mode_reg <= MODE_TCAS;
            last_level_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                table_mode_reg <= cfg_wdata;
            end
            if (s1_move) begin
                last_level_reg <= pick_result.thr.level_id;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register for the accepted beat.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            msl_reg    <= alt_msl_ft;
            msl_ok_reg <= msl_valid;
            agl_reg    <= alt_agl_ft;
            agl_ok_reg <= agl_valid;
            gear_reg   <= gear_down;
            force_reg  <= force_level;
        end
    end

    // Band tests and level resolution.
    csls_pick u_pick (
        .table_mode  (table_mode_reg),
        .last_level  (last_level_reg),
        .alt_msl_ft  (msl_reg),
        .msl_valid   (msl_ok_reg),
        .alt_agl_ft  (agl_reg),
        .agl_valid   (agl_ok_reg),
        .gear_down   (gear_reg),
        .force_level (force_reg),
        .result      (pick_result)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (s1_move) begin
            result_reg <= pick_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level_id    = result_reg.thr.level_id;
    assign tau_ta_s    = result_reg.thr.tau_ta_s;
    assign tau_ra_s    = result_reg.thr.tau_ra_s;
    assign dmod_ta_cnm = result_reg.thr.dmod_ta_cnm;
    assign dmod_ra_cnm = result_reg.thr.dmod_ra_cnm;
    assign zthr_ta_ft  = result_reg.thr.zthr_ta_ft;
    assign zthr_ra_ft  = result_reg.thr.zthr_ra_ft;
    assign alim_ft     = result_reg.thr.alim_ft;
    assign force_error = result_reg.force_error;

    // The input side only stalls while the input register holds a beat.
    `CSLS_ASSERT_SAME(a_stall_needs_beat, in_stall, s1_valid_reg, "stall with empty input register")
    // The last level follows each result that enters the output register.
    `CSLS_ASSERT_NEXT(a_last_tracks_out, s1_move, last_level_reg == level_id, "last level mismatch")
    // A shown result always names a real level.
    `CSLS_ASSERT_SAME(a_level_nonzero, out_valid, level_id != 4'd0, "level zero shown")
    // A clamped force lands on the last level of one of the tables.
    `CSLS_ASSERT_SAME(a_clamp_last, out_valid && force_error, (level_id == 4'd8) || (level_id == 4'd3), "clamp level wrong")

endmodule

// ===== rtl/csls_pick.sv =====
// ----------------------------------------------------------------------------
// Sensitivity level pick
// Tests all bands of the active table in parallel, widens the band picked
// last by its hysteresis and resolves forced, fallback and scanned levels.
// ----------------------------------------------------------------------------
module csls_pick
    import csls_pkg::*;
(
    input  logic                table_mode,
    input  logic [LEVEL_W-1:0]  last_level,
    input  logic signed [16:0]  alt_msl_ft,
    input  logic                msl_valid,
    input  logic signed [14:0]  alt_agl_ft,
    input  logic                agl_valid,
    input  logic                gear_down,
    input  logic [3:0]          force_level,
    output result_t             result
);

    logic [NUM_BANDS-1:0]       hit;
    logic [BAND_IDX_W-1:0]      scan_idx;
    logic                       scan_found;
    logic [BAND_IDX_W-1:0]      pick_idx;
    logic                       force_err;
    logic [LEVEL_W-1:0]         count;
    logic signed [BOUND_W:0]    msl_ext;
    logic signed [BOUND_W:0]    agl_ext;
    band_t                      pick_band;

    assign count   = band_count(table_mode);
    assign msl_ext = {{(BOUND_W - 16){alt_msl_ft[16]}}, alt_msl_ft};
    assign agl_ext = {{(BOUND_W - 14){alt_agl_ft[14]}}, alt_agl_ft};

    // Per-band range and gear tests.
    always_comb
    begin
        band_t                   b;
        logic                    widen;
        logic signed [BOUND_W:0] lo_eff;
        logic signed [BOUND_W:0] hi_eff;
        logic signed [BOUND_W:0] val;
        logic                    in_range;
        logic                    range_ok;
        logic                    gear_ok;
        for (int i = 0; i < NUM_BANDS; i++) begin
            b        = band_entry(table_mode, BAND_IDX_W'(i));
            widen    = (last_level == LEVEL_W'(i + 1));
            lo_eff   = {b.lo[BOUND_W-1], b.lo}
                     - (widen ? $signed({{(BOUND_W + 1 - HYST_W){1'b0}}, b.hyst_lo})
                              : $signed({(BOUND_W + 1){1'b0}}));
            hi_eff   = {b.hi[BOUND_W-1], b.hi}
                     + (widen ? $signed({{(BOUND_W + 1 - HYST_W){1'b0}}, b.hyst_hi})
                              : $signed({(BOUND_W + 1){1'b0}}));
            val      = b.on_agl ? agl_ext : msl_ext;
            in_range = (b.lo_open || (val >= lo_eff)) && (b.hi_open || (val < hi_eff));
            range_ok = b.on_agl ? (agl_valid && in_range) : in_range;
            gear_ok  = ((b.gear == GEAR_DN) && gear_down)
                    || ((b.gear == GEAR_UP) && !gear_down);
            hit[i]   = (LEVEL_W'(i) < count) && (range_ok || gear_ok);
        end
    end

    // First matching band in table order.
    always_comb
    begin
        scan_idx   = '0;
        scan_found = 1'b0;
        for (int i = NUM_BANDS - 1; i >= 0; i--) begin
            if (hit[i]) begin
                scan_idx   = BAND_IDX_W'(i);
                scan_found = 1'b1;
            end
        end
    end

    // Forced level wins; then the scan; otherwise the fallback level.
    always_comb
    begin
        pick_idx  = fallback_idx(table_mode);
        force_err = 1'b0;
        priority if (force_level != 4'd0) begin
            if (force_level > count) begin
                pick_idx  = BAND_IDX_W'(count - 4'd1);
                force_err = 1'b1;
            end else begin
                pick_idx  = BAND_IDX_W'(force_level - 4'd1);
            end
        end else if (msl_valid && scan_found) begin
            pick_idx = scan_idx;
        end else begin
            pick_idx = fallback_idx(table_mode);
        end
    end

    assign pick_band          = band_entry(table_mode, pick_idx);
    assign result.thr         = pick_band.thr;
    assign result.force_error = force_err;

endmodule

// ===== tb/level_select_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensitivity level select checker
// Watches the input, output and table mode ports of the level select block,
// predicts the level and advisory thresholds of every accepted input beat,
// and compares each accepted output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module level_select_checker
    import csls_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [16:0] alt_msl_ft,
    input  logic               msl_valid,
    input  logic signed [14:0] alt_agl_ft,
    input  logic               agl_valid,
    input  logic               gear_down,
    input  logic [3:0]         force_level,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [3:0]         level_id,
    input  logic [5:0]         tau_ta_s,
    input  logic [5:0]         tau_ra_s,
    input  logic [7:0]         dmod_ta_cnm,
    input  logic [6:0]         dmod_ra_cnm,
    input  logic [10:0]        zthr_ta_ft,
    input  logic [9:0]         zthr_ra_ft,
    input  logic [9:0]         alim_ft,
    input  logic               force_error,
    output int                 fail_count,
    output int                 pending,
    output int                 n_checked
);

    // Open band ends sit far outside every altitude the ports can carry.
    localparam int OPEN_END = 1 << 24;

    // One altitude band with its thresholds.
    typedef struct packed {
        logic       on_agl;
        logic [1:0] gear;
        int         lo;
        int         hi;
        int         widen_lo;
        int         widen_hi;
        thresh_t    thr;
    } alt_band_t;

    // Predicted results still waiting for their output beat.
    result_t    level_q[$];
    result_t    due;
    result_t    fresh;
    logic       mode;
    logic [3:0] last_level;

    // Builds one band from plain numbers.
    function automatic alt_band_t band_row(
        input logic       on_agl,
        input logic [1:0] gear,
        input int         lo,
        input int         hi,
        input int         widen_lo,
        input int         widen_hi,
        input int         id,
        input int         tta,
        input int         tra,
        input int         dta,
        input int         dra,
        input int         zta,
        input int         zra,
        input int         alim
    );
        alt_band_t b;
        b.on_agl          = on_agl;
        b.gear            = gear;
        b.lo              = lo;
        b.hi              = hi;
        b.widen_lo        = widen_lo;
        b.widen_hi        = widen_hi;
        b.thr.level_id    = 4'(id);
        b.thr.tau_ta_s    = 6'(tta);
        b.thr.tau_ra_s    = 6'(tra);
        b.thr.dmod_ta_cnm = 8'(dta);
        b.thr.dmod_ra_cnm = 7'(dra);
        b.thr.zthr_ta_ft  = 11'(zta);
        b.thr.zthr_ra_ft  = 10'(zra);
        b.thr.alim_ft     = 10'(alim);
        return b;
    endfunction

    // The two band tables, scanned in index order.
    function automatic alt_band_t band_at(input logic tab_mode, input int idx);
        alt_band_t b;
        b = '0;
        if (tab_mode == MODE_GEAR)
        begin
            case (idx)
                0: b = band_row(1'b1, GEAR_NONE, -OPEN_END, 50, 0, 10,
                                1, 0, 0, 0, 0, 0, 0, 0);
                1: b = band_row(1'b1, GEAR_DN, 50, 2000, 10, 100,
                                2, 20, 0, 20, 0, 600, 0, 0);
                2: b = band_row(1'b1, GEAR_UP, 2000, OPEN_END, 100, 100,
                                3, 30, 0, 55, 0, 800, 0, 0);
                default: b = '0;
            endcase
        end
        else
        begin
            case (idx)
                0: b = band_row(1'b1, GEAR_NONE, -OPEN_END, 50, 0, 10,
                                1, 0, 0, 0, 0, 0, 0, 0);
                1: b = band_row(1'b1, GEAR_NONE, 50, 1000, 10, 100,
                                2, 20, 0, 30, 0, 850, 0, 0);
                2: b = band_row(1'b1, GEAR_NONE, 1000, 2350, 100, 200,
                                3, 25, 15, 33, 20, 850, 600, 300);
                3: b = band_row(1'b0, GEAR_NONE, -OPEN_END, 5000, 0, 500,
                                4, 30, 20, 48, 35, 850, 600, 300);
                4: b = band_row(1'b0, GEAR_NONE, 5000, 10000, 500, 500,
                                5, 40, 25, 75, 55, 850, 600, 350);
                5: b = band_row(1'b0, GEAR_NONE, 10000, 20000, 500, 500,
                                6, 45, 30, 100, 80, 850, 600, 400);
                6: b = band_row(1'b0, GEAR_NONE, 20000, 42000, 500, 500,
                                7, 48, 35, 130, 110, 850, 700, 600);
                7: b = band_row(1'b0, GEAR_NONE, 42000, OPEN_END, 500, 500,
                                8, 48, 35, 130, 110, 1200, 800, 700);
                default: b = '0;
            endcase
        end
        return b;
    endfunction

    // Picks the level for one beat. A forced level wins, an invalid baro
    // altitude takes the fallback, otherwise the first matching band is used,
    // with the previously selected band widened by its hysteresis.
    function automatic result_t pick_level(
        input logic        tab_mode,
        input logic [3:0]  prev,
        input int          msl,
        input logic        msl_ok,
        input int          agl,
        input logic        agl_ok,
        input logic        gear_dn,
        input logic [3:0]  force_lvl
    );
        result_t   r;
        alt_band_t b;
        int        count;
        int        pick;
        int        lo;
        int        hi;
        logic      found;
        logic      hit;
        count         = (tab_mode == MODE_GEAR) ? 3 : 8;
        pick          = (tab_mode == MODE_GEAR) ? 1 : 3;
        found         = 1'b0;
        r.force_error = 1'b0;
        if (force_lvl != 0)
        begin
            if (int'(force_lvl) > count)
            begin
                pick          = count - 1;
                r.force_error = 1'b1;
            end
            else
            begin
                pick = int'(force_lvl) - 1;
            end
        end
        else if (msl_ok)
        begin
            for (int i = 0; i < count; i++)
            begin
                if (!found)
                begin
                    b  = band_at(tab_mode, i);
                    lo = b.lo;
                    hi = b.hi;
                    if (prev == b.thr.level_id)
                    begin
                        lo = lo - b.widen_lo;
                        hi = hi + b.widen_hi;
                    end
                    if (b.on_agl)
                        hit = agl_ok && agl >= lo && agl < hi;
                    else
                        hit = msl >= lo && msl < hi;
                    if (b.gear == GEAR_DN && gear_dn)
                        hit = 1'b1;
                    if (b.gear == GEAR_UP && !gear_dn)
                        hit = 1'b1;
                    if (hit)
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
            end
        end
        b     = band_at(tab_mode, pick);
        r.thr = b.thr;
        return r;
    endfunction

    // Reports one field that differs from its prediction.
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Output beats are checked before input beats of the same edge are
    // predicted; a result never leaves in the cycle its beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_q.delete();
            mode       = MODE_TCAS;
            last_level = '0;
            pending    = 0;
            fail_count = 0;
            n_checked  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (level_q.size() == 0)
                begin
                    $error("output beat with no input beat outstanding");
                    fail_count++;
                end
                else
                begin
                    due = level_q.pop_front();
                    check_field("level_id", due.thr.level_id, level_id);
                    check_field("tau_ta_s", due.thr.tau_ta_s, tau_ta_s);
                    check_field("tau_ra_s", due.thr.tau_ra_s, tau_ra_s);
                    check_field("dmod_ta_cnm", due.thr.dmod_ta_cnm, dmod_ta_cnm);
                    check_field("dmod_ra_cnm", due.thr.dmod_ra_cnm, dmod_ra_cnm);
                    check_field("zthr_ta_ft", due.thr.zthr_ta_ft, zthr_ta_ft);
                    check_field("zthr_ra_ft", due.thr.zthr_ra_ft, zthr_ra_ft);
                    check_field("alim_ft", due.thr.alim_ft, alim_ft);
                    check_field("force_error", due.force_error, force_error);
                    n_checked++;
                end
            end
            if (in_valid && !in_stall)
            begin
                fresh = pick_level(mode, last_level, int'(alt_msl_ft), msl_valid,
                                   int'(alt_agl_ft), agl_valid, gear_down,
                                   force_level);
                last_level = fresh.thr.level_id;
                level_q.push_back(fresh);
            end
            if (cfg_we)
                mode = cfg_wdata;
            pending = level_q.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensitivity level select testbench
// Drives altitude beats through both band tables: a directed set at band
// edges, hysteresis and forced levels, then climbing and descending
// altitude runs mixed with edge probes and noise, with random gaps and
// output stalls. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import csls_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               in_valid;
    logic               in_stall;
    logic signed [16:0] alt_msl_ft;
    logic               msl_valid;
    logic signed [14:0] alt_agl_ft;
    logic               agl_valid;
    logic               gear_down;
    logic [3:0]         force_level;
    logic               out_valid;
    logic               out_stall;
    logic [3:0]         level_id;
    logic [5:0]         tau_ta_s;
    logic [5:0]         tau_ra_s;
    logic [7:0]         dmod_ta_cnm;
    logic [6:0]         dmod_ra_cnm;
    logic [10:0]        zthr_ta_ft;
    logic [9:0]         zthr_ra_ft;
    logic [9:0]         alim_ft;
    logic               force_error;

    int   fail_count;
    int   pending;
    int   n_checked;
    bit   calm;
    int   stall_left;
    int   n_beats;
    int   n_forced;
    int   n_no_baro;
    int   n_mode_writes;
    int   cur_msl;
    int   cur_agl;
    int   climb;
    logic cur_gear;

    collision_sensitivity_level_select u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .alt_msl_ft  (alt_msl_ft),
        .msl_valid   (msl_valid),
        .alt_agl_ft  (alt_agl_ft),
        .agl_valid   (agl_valid),
        .gear_down   (gear_down),
        .force_level (force_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .level_id    (level_id),
        .tau_ta_s    (tau_ta_s),
        .tau_ra_s    (tau_ra_s),
        .dmod_ta_cnm (dmod_ta_cnm),
        .dmod_ra_cnm (dmod_ra_cnm),
        .zthr_ta_ft  (zthr_ta_ft),
        .zthr_ra_ft  (zthr_ra_ft),
        .alim_ft     (alim_ft),
        .force_error (force_error)
    );

    level_select_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .alt_msl_ft  (alt_msl_ft),
        .msl_valid   (msl_valid),
        .alt_agl_ft  (alt_agl_ft),
        .agl_valid   (agl_valid),
        .gear_down   (gear_down),
        .force_level (force_level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .level_id    (level_id),
        .tau_ta_s    (tau_ta_s),
        .tau_ra_s    (tau_ra_s),
        .dmod_ta_cnm (dmod_ta_cnm),
        .dmod_ra_cnm (dmod_ra_cnm),
        .zthr_ta_ft  (zthr_ta_ft),
        .zthr_ra_ft  (zthr_ra_ft),
        .alim_ft     (alim_ft),
        .force_error (force_error),
        .fail_count  (fail_count),
        .pending     (pending),
        .n_checked   (n_checked)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Band boundaries: radio altitude ones first, then baro ones.
    function automatic int band_edge(input int k);
        case (k)
            0:       return 50;
            1:       return 1000;
            2:       return 2000;
            3:       return 2350;
            4:       return 5000;
            5:       return 10000;
            6:       return 20000;
            default: return 42000;
        endcase
    endfunction

    // Output stalls, held off while the run is calm.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall = 1'b0;
                if (!calm && $urandom_range(0, 2) == 0)
                    stall_left = idle_len();
            end
        end
    end

    // Presents one input beat after a random gap and waits for its acceptance.
    task automatic send_beat(input int msl, input logic mv, input int agl,
                             input logic av, input logic gear, input int lvl);
        int gap;
        gap = calm ? 0 : idle_len();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        alt_msl_ft  = 17'(msl);
        msl_valid   = mv;
        alt_agl_ft  = 15'(agl);
        agl_valid   = av;
        gear_down   = gear;
        force_level = 4'(lvl);
        in_valid    = 1'b1;
        do @(posedge clk); while (in_stall);
        n_beats++;
        if (lvl != 0)
            n_forced++;
        if (!mv)
            n_no_baro++;
    endtask

    // Writes the table mode once every outstanding result has come back.
    task automatic write_mode(input logic m);
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(negedge clk);
        cfg_we = 1'b0;
        n_mode_writes++;
    endtask

    // Mostly smooth climbs and descents with reversals, which cross band
    // edges both ways; some probes right at an edge, and some noise.
    task automatic random_beat();
        int   kind;
        int   step;
        int   k;
        int   msl;
        int   agl;
        int   lvl;
        logic mv;
        logic av;
        kind = $urandom_range(0, 99);
        mv   = ($urandom_range(0, 19) != 0);
        av   = ($urandom_range(0, 9) != 0);
        lvl  = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 15) : 0;
        if ($urandom_range(0, 19) == 0)
            cur_gear = ~cur_gear;
        msl = cur_msl;
        agl = cur_agl;
        if (kind < 70)
        begin
            if ($urandom_range(0, 7) == 0)
                climb = -climb;
            step    = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 1500);
            cur_msl = clamp(cur_msl + climb * step, -2048, 65535);
            cur_agl = clamp(cur_agl + climb * step, -2048, 16383);
            msl     = cur_msl;
            agl     = cur_agl;
        end
        else if (kind < 85)
        begin
            k = $urandom_range(0, 7);
            if (k < 4)
                agl = clamp(band_edge(k) + int'($urandom_range(0, 1200)) - 600,
                            -2048, 16383);
            else
                msl = clamp(band_edge(k) + int'($urandom_range(0, 1200)) - 600,
                            -2048, 65535);
        end
        else
        begin
            msl      = int'($urandom_range(0, 67583)) - 2048;
            agl      = int'($urandom_range(0, 18431)) - 2048;
            mv       = $urandom_range(0, 1);
            av       = $urandom_range(0, 1);
            lvl      = $urandom_range(0, 15);
            cur_gear = $urandom_range(0, 1);
        end
        send_beat(msl, mv, agl, av, cur_gear, lvl);
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = MODE_TCAS;
        in_valid      = 1'b0;
        alt_msl_ft    = '0;
        msl_valid     = 1'b0;
        alt_agl_ft    = '0;
        agl_valid     = 1'b0;
        gear_down     = 1'b0;
        force_level   = '0;
        calm          = 1'b0;
        n_beats       = 0;
        n_forced      = 0;
        n_no_baro     = 0;
        n_mode_writes = 0;
        cur_gear      = 1'b0;
        climb         = 1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Eight-level table from reset: field extremes, radio altitude
        // hysteresis around the lowest edges, baro edges, invalid altitudes.
        send_beat(-2048, 1'b1, -2048, 1'b1, 1'b0, 0);
        send_beat(65535, 1'b1, 16383, 1'b1, 1'b1, 0);
        send_beat(3000, 1'b1, 49, 1'b1, 1'b0, 0);
        send_beat(3000, 1'b1, 55, 1'b1, 1'b0, 0);
        send_beat(3000, 1'b1, 60, 1'b1, 1'b0, 0);
        send_beat(3000, 1'b1, 1050, 1'b1, 1'b0, 0);
        send_beat(3000, 1'b1, 2400, 1'b1, 1'b0, 0);
        send_beat(3000, 1'b1, 500, 1'b0, 1'b0, 0);
        send_beat(4999, 1'b1, 0, 1'b0, 1'b0, 0);
        send_beat(5400, 1'b1, 0, 1'b0, 1'b0, 0);
        send_beat(5600, 1'b1, 0, 1'b0, 1'b0, 0);
        send_beat(10000, 1'b1, 0, 1'b0, 1'b0, 0);
        send_beat(42000, 1'b1, 0, 1'b0, 1'b0, 0);
        send_beat(41600, 1'b1, 0, 1'b0, 1'b0, 0);
        send_beat(20000, 1'b0, 0, 1'b1, 1'b0, 0);
        // Forced levels: first, last, and beyond the table.
        send_beat(20000, 1'b0, 0, 1'b1, 1'b0, 1);
        send_beat(20000, 1'b1, 0, 1'b1, 1'b0, 8);
        send_beat(20000, 1'b1, 0, 1'b1, 1'b1, 9);
        send_beat(-2048, 1'b1, 16383, 1'b0, 1'b1, 15);

        // Gear-tested table, entered with a last level it does not have.
        write_mode(MODE_GEAR);
        send_beat(3000, 1'b1, 3000, 1'b0, 1'b1, 0);
        send_beat(3000, 1'b1, 3000, 1'b0, 1'b0, 0);
        send_beat(0, 1'b1, 30, 1'b1, 1'b1, 0);
        send_beat(0, 1'b0, 30, 1'b1, 1'b1, 0);
        send_beat(0, 1'b1, 30, 1'b1, 1'b0, 3);
        send_beat(0, 1'b1, 30, 1'b1, 1'b0, 4);
        send_beat(0, 1'b1, 30, 1'b1, 1'b0, 15);

        // Random phases, alternating the table mode.
        for (int p = 0; p < 6; p++)
        begin
            write_mode((p % 2) ? MODE_GEAR : MODE_TCAS);
            cur_msl = $urandom_range(0, 45000);
            cur_agl = int'($urandom_range(0, 3100)) - 100;
            climb   = $urandom_range(0, 1) ? 1 : -1;
            for (int k = 0; k < 272; k++)
            begin
                if (k % 90 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                random_beat();
            end
        end

        // Drain, then let the pipeline settle.
        @(negedge clk);
        in_valid = 1'b0;
        calm     = 1'b1;
        while (pending != 0) @(negedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d beats over %0d table mode writes: %0d forced, %0d with baro invalid.",
                 n_beats, n_mode_writes, n_forced, n_no_baro);
        $display("Checked %0d result beats, %0d mismatches.", n_checked, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
